// ===== rtl/core/lcdws_pkg.sv =====
// Shared types and constants for the character LCD write sequencer.
// Used by lcdws_step and char_lcd_parallel_write_sequencer_unit.
package lcdws_pkg;

	localparam int unsigned ROWS    = 4;
	localparam int unsigned COLUMNS = 20;

	localparam int unsigned WAIT_W = 13;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned INDEX_W = 3;
	localparam int unsigned DATA_W = 13;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_COMMAND = 3'd1;
	localparam logic [2:0] OP_CHAR    = 3'd2;
	localparam logic [2:0] OP_CURSOR  = 3'd3;
	localparam logic [2:0] OP_INIT    = 3'd4;

	localparam logic [INDEX_W-1:0] REG_ENABLE_PULSE    = 3'd0;
	localparam logic [INDEX_W-1:0] REG_SETTLE          = 3'd1;
	localparam logic [INDEX_W-1:0] REG_CLEAR_WAIT      = 3'd2;
	localparam logic [INDEX_W-1:0] REG_FUNCTION_SET    = 3'd3;
	localparam logic [INDEX_W-1:0] REG_DISPLAY_CONTROL = 3'd4;

	localparam logic [STEP_W-1:0] STEP_IDLE          = 4'd0;
	localparam logic [STEP_W-1:0] STEP_POWER         = 4'd1;
	localparam logic [STEP_W-1:0] STEP_INIT_FIRST    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_INIT_LAST     = 4'd13;
	localparam logic [STEP_W-1:0] STEP_SINGLE_PULSE  = 4'd14;
	localparam logic [STEP_W-1:0] STEP_SINGLE_SETTLE = 4'd15;

	localparam logic [7:0] CMD_WAKE  = 8'h30;
	localparam logic [7:0] CMD_CLEAR = 8'h01;

	localparam logic [WAIT_W-1:0] CURSOR_EXTRA = 13'd100;
	localparam logic [WAIT_W-1:0] WAKE_EXTRA_FIRST = 13'd4500;
	localparam logic [WAIT_W-1:0] WAKE_EXTRA_NEXT  = 13'd150;

	localparam logic [7:0]        RST_ENABLE_PULSE    = 8'd1;
	localparam logic [9:0]        RST_SETTLE          = 10'd50;
	localparam logic [WAIT_W-1:0] RST_CLEAR_WAIT      = 13'd2000;
	localparam logic [7:0]        RST_FUNCTION_SET    = 8'h38;
	localparam logic [7:0]        RST_DISPLAY_CONTROL = 8'h0E;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] value_byte;
		logic [2:0] row;
		logic [4:0] column;
	} lcdws_item_t;

	typedef struct packed {
		logic [7:0]        enable_pulse_us;
		logic [9:0]        settle_us;
		logic [WAIT_W-1:0] clear_wait_us;
		logic [7:0]        function_set_word;
		logic [7:0]        display_control_word;
	} lcdws_cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [WAIT_W-1:0] wait_count;
		logic [WAIT_W-1:0] extra_wait;
		logic [7:0]        held_byte;
		logic              select_level;
		logic              enable_level;
	} lcdws_state_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       register_select;
		logic       read_write;
		logic       enable;
		logic       busy_res;
		logic       rejected;
	} lcdws_result_t;

	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		begin
			unique case (r)
				2'd0: b = 8'h80;
				2'd1: b = 8'hC0;
				2'd2: b = 8'h94;
				default: b = 8'hD4;
			endcase
			return b;
		end
	endfunction

endpackage

// ===== rtl/core/lcdws_step.sv =====
// Next-state and result logic for one transaction of the LCD write sequencer.
// Depends on lcdws_pkg.
module lcdws_step
	import lcdws_pkg::*;
(
	input  lcdws_state_t  state,
	input  lcdws_item_t   item,
	input  lcdws_cfg_t    cfg,
	output lcdws_state_t  state_next,
	output lcdws_result_t result
);

	function automatic lcdws_state_t start_write(
		input lcdws_state_t      cur,
		input logic [7:0]        b,
		input logic              rs,
		input logic [WAIT_W-1:0] extra,
		input logic [STEP_W-1:0] step,
		input logic [7:0]        pulse
	);
		lcdws_state_t s;
		begin
			s = cur;
			s.held_byte    = b;
			s.select_level = rs;
			s.enable_level = 1'b1;
			s.wait_count   = {{(WAIT_W-8){1'b0}}, pulse};
			s.extra_wait   = extra;
			s.step         = step;
			return s;
		end
	endfunction

	logic [2:0]        init_k;
	logic [7:0]        init_byte;
	logic [WAIT_W-1:0] init_extra;
	logic [WAIT_W-1:0] wait_dec;
	logic [WAIT_W-1:0] extra_dec;
	logic              cursor_ok;
	logic [7:0]        cursor_addr;
	logic              idle;
	logic              rej;

	always_comb begin
		if (state.step == STEP_POWER) begin
			init_k = 3'd0;
		end else begin
			init_k = state.step[3:1];
		end
		unique case (init_k)
			3'd0: begin
				init_byte  = CMD_WAKE;
				init_extra = WAKE_EXTRA_FIRST;
			end
			3'd1, 3'd2: begin
				init_byte  = CMD_WAKE;
				init_extra = WAKE_EXTRA_NEXT;
			end
			3'd3: begin
				init_byte  = cfg.function_set_word;
				init_extra = '0;
			end
			3'd4: begin
				init_byte  = cfg.display_control_word;
				init_extra = '0;
			end
			default: begin
				init_byte  = CMD_CLEAR;
				init_extra = cfg.clear_wait_us;
			end
		endcase
	end

	always_comb begin
		wait_dec  = (state.wait_count != '0) ? state.wait_count - 13'd1 : state.wait_count;
		extra_dec = (state.wait_count == '0 && state.extra_wait != '0) ?
			state.extra_wait - 13'd1 : state.extra_wait;
		cursor_ok = (state.step == STEP_IDLE) && (item.row >= 3'd1)
			&& ({29'd0, item.row} <= ROWS) && (item.column >= 5'd1)
			&& ({27'd0, item.column} <= COLUMNS);
		cursor_addr = row_base(2'(item.row - 3'd1)) + {3'd0, item.column} - 8'd1;
		idle = (state.step == STEP_IDLE);
		rej = 1'b0;
		state_next = state;
		unique case (item.operation)
			OP_TICK: begin
				priority if (state.step == STEP_IDLE) begin
					state_next = state;
				end else if (state.step == STEP_POWER) begin
					state_next.wait_count = wait_dec;
					if (wait_dec == '0) begin
						state_next = start_write(state, init_byte, 1'b0, init_extra,
							STEP_INIT_FIRST, cfg.enable_pulse_us);
					end
				end else if (!state.step[0]) begin
					state_next.wait_count = wait_dec;
					if (wait_dec == '0) begin
						state_next.enable_level = 1'b0;
						state_next.wait_count   = {3'd0, cfg.settle_us};
						state_next.step         = state.step + 4'd1;
					end
				end else begin
					state_next.wait_count = wait_dec;
					state_next.extra_wait = extra_dec;
					if (wait_dec == '0 && extra_dec == '0) begin
						if (state.step == STEP_SINGLE_SETTLE || state.step == STEP_INIT_LAST) begin
							state_next.step = STEP_IDLE;
						end else begin
							state_next = start_write(state, init_byte, 1'b0, init_extra,
								state.step + 4'd1, cfg.enable_pulse_us);
						end
					end
				end
			end
			OP_COMMAND, OP_CHAR: begin
				if (!idle) begin
					rej = 1'b1;
				end else begin
					state_next = start_write(state, item.value_byte,
						item.operation == OP_CHAR, '0, STEP_SINGLE_PULSE,
						cfg.enable_pulse_us);
				end
			end
			OP_CURSOR: begin
				if (!cursor_ok) begin
					rej = 1'b1;
				end else begin
					state_next = start_write(state, cursor_addr, 1'b0, CURSOR_EXTRA,
						STEP_SINGLE_PULSE, cfg.enable_pulse_us);
				end
			end
			OP_INIT: begin
				if (!idle) begin
					rej = 1'b1;
				end else begin
					state_next.enable_level = 1'b0;
					state_next.wait_count   = cfg.clear_wait_us;
					state_next.extra_wait   = '0;
					state_next.step         = STEP_POWER;
				end
			end
			default: begin
				rej = 1'b1;
			end
		endcase
		result.bus_byte        = state_next.held_byte;
		result.register_select = state_next.select_level;
		result.read_write      = 1'b0;
		result.enable          = state_next.enable_level;
		result.busy_res        = (state_next.step != STEP_IDLE);
		result.rejected        = rej;
	end

endmodule

// ===== rtl/core/char_lcd_parallel_write_sequencer_unit.sv =====
// Top level of the character LCD write sequencer: input register, sequencer
// state, configuration registers and result register. Depends on lcdws_pkg, lcdws_step.
//
// Usage:
//   Request channel (request_valid / request_stall) carries one transaction:
//   operation, value_byte, row, column. Operation 0 is a one-microsecond tick;
//   1..4 start a command, character, cursor or init sequence when idle.
//   Result channel (result_valid / result_stall) returns exactly one result per
//   transaction: the LCD pin levels after it was applied, busy_res and rejected.
//   Order: a transaction once accepted is captured in the input register;
//   it is applied to the sequencer state and written to the result register
//   together when it advances, and is shown on the result register from then on.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   Receiver stall: the result register holds; the input register still fills,
//   then request_stall rises until the result is taken.
//   Reset: sequencer idle, configuration at defaults, both channels empty; result register not reset.
//   Configuration: write_enable, register_index, write_data; write only while idle.
module char_lcd_parallel_write_sequencer_unit
	import lcdws_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_enable,
	input  logic [INDEX_W-1:0] register_index,
	input  logic [DATA_W-1:0]  write_data,
	input  logic               request_valid,
	output logic               request_stall,
	input  logic [2:0]         operation,
	input  logic [7:0]         value_byte,
	input  logic [2:0]         row,
	input  logic [4:0]         column,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         bus_byte,
	output logic               register_select,
	output logic               read_write,
	output logic               enable,
	output logic               busy_res,
	output logic               rejected
);

	lcdws_item_t   item_s1;
	logic          valid_s1;
	lcdws_state_t  state_q;
	lcdws_state_t  state_next;
	lcdws_cfg_t    cfg_q;
	lcdws_result_t result_s2;
	lcdws_result_t result_next;
	logic          valid_s2;
	logic          advance;
	logic          accept;

	assign advance       = valid_s1 && (!valid_s2 || !result_stall);
	assign request_stall = valid_s1 && !advance;
	assign accept        = request_valid && !request_stall;

	lcdws_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.cfg        (cfg_q),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
			cfg_q.enable_pulse_us      <= RST_ENABLE_PULSE;
			cfg_q.settle_us            <= RST_SETTLE;
			cfg_q.clear_wait_us        <= RST_CLEAR_WAIT;
			cfg_q.function_set_word    <= RST_FUNCTION_SET;
			cfg_q.display_control_word <= RST_DISPLAY_CONTROL;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
			if (write_enable) begin
				unique case (register_index)
					REG_ENABLE_PULSE:    cfg_q.enable_pulse_us      <= write_data[7:0];
					REG_SETTLE:          cfg_q.settle_us            <= write_data[9:0];
					REG_CLEAR_WAIT:      cfg_q.clear_wait_us        <= write_data;
					REG_FUNCTION_SET:    cfg_q.function_set_word    <= write_data[7:0];
					REG_DISPLAY_CONTROL: cfg_q.display_control_word <= write_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{operation: operation, value_byte: value_byte, row: row,
				column: column};
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid    = valid_s2;
	assign bus_byte        = result_s2.bus_byte;
	assign register_select = result_s2.register_select;
	assign read_write      = result_s2.read_write;
	assign enable          = result_s2.enable;
	assign busy_res        = result_s2.busy_res;
	assign rejected        = result_s2.rejected;

endmodule
